// ----- design/jsu_pkg.sv -----
// ---------------------------------------------------------------------------
// jsu_pkg : shared types and constants
// Status codes, queue job format and hex digit decode for the JSON string
// unescape unit.
// ---------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  typedef enum logic [3:0] {
    ST_DATA      = 4'd0,
    ST_END       = 4'd1,
    ST_CTRL      = 4'd2,
    ST_BADHEX    = 4'd3,
    ST_LONELOW   = 4'd4,
    ST_BADSECOND = 4'd5,
    ST_MISSING   = 4'd6,
    ST_BADESC    = 4'd7,
    ST_UNTERM    = 4'd8
  } status_t;

  // ASCII codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Code point boundaries
  localparam logic [15:0] CP_HI_FIRST = 16'hd800;
  localparam logic [15:0] CP_HI_LAST  = 16'hdbff;
  localparam logic [15:0] CP_LO_FIRST = 16'hdc00;
  localparam logic [15:0] CP_LO_LAST  = 16'hdfff;
  localparam logic [15:0] CP_BMP_LOW  = 16'hd7ff;
  localparam logic [15:0] CP_BMP_HIGH = 16'he000;
  localparam logic [20:0] CP_PAIR_BASE = 21'h10000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One decoded byte's worth of results: 1..4 data words or one status word
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
    status_t         status;
  } job_t;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/jsu_ifs.sv -----
// ---------------------------------------------------------------------------
// jsu channel interfaces
// Raw string byte channel and decoded UTF-8 word channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface jsu_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       end_of_input;

  modport source (output valid, data_byte, first_byte, end_of_input, input ready);
  modport sink   (input valid, data_byte, first_byte, end_of_input, output ready);
endinterface

interface jsu_utf8_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] status;
  logic       last_result;

  modport source (output valid, out_byte, status, last_result, input ready);
  modport sink   (input valid, out_byte, status, last_result, output ready);
endinterface

`default_nettype wire

// ----- design/jsu_front.sv -----
// ---------------------------------------------------------------------------
// jsu_front : byte classifier and decode state
// Takes one raw byte per word, updates escape/hex/surrogate state and
// builds a job of up to four UTF-8 bytes or one status for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  wire logic       clk,
  input  wire logic       rst,
  jsu_raw_if.sink         raw,
  input  wire logic       q_full,
  output logic            push,
  output jsu_pkg::job_t   job
);
  import jsu_pkg::*;

  logic        active, esc, hsp;
  logic [2:0]  left;
  logic [15:0] acc;
  logic [9:0]  hsb;

  logic        active_next, esc_next, hsp_next;
  logic [2:0]  left_next;
  logic [15:0] acc_next;
  logic [9:0]  hsb_next;

  logic        act, esc_e, hsp_e;
  logic [2:0]  left_e, left_dec;
  logic [15:0] acc_e, acc_hex;
  logic [9:0]  hsb_e;
  logic [4:0]  hx;
  logic [7:0]  c;
  logic [20:0] cp_full, enc_cp;
  logic        enc_pair, emit_enc, job_valid, fin;
  status_t     fin_st;
  logic [1:0]      enc_last;
  logic [3:0][7:0] enc_bytes;
  logic        accept;

  assign c      = raw.data_byte;
  assign accept = raw.valid & raw.ready;
  assign raw.ready = ~q_full;
  assign push   = accept & job_valid;

  // effective state: a first byte starts from a clean slate
  assign act    = raw.first_byte | active;
  assign esc_e  = raw.first_byte ? 1'b0  : esc;
  assign left_e = raw.first_byte ? 3'd0  : left;
  assign acc_e  = raw.first_byte ? 16'd0 : acc;
  assign hsp_e  = raw.first_byte ? 1'b0  : hsp;
  assign hsb_e  = raw.first_byte ? 10'd0 : hsb;

  // a completed code unit with a high half waiting is always the low half
  assign enc_pair = hsp_e;

  assign hx       = hex_decode(c);
  assign left_dec = left_e - 3'd1;
  assign acc_hex  = acc_e | (16'(hx[3:0]) << {left_dec[1:0], 2'b00});
  assign cp_full  = CP_PAIR_BASE + {1'b0, hsb_e, acc_hex[9:0]};
  assign enc_cp   = enc_pair ? cp_full : {5'd0, acc_hex};

  // UTF-8 encoder
  always_comb begin
    enc_bytes = '0;
    if (enc_cp < 21'h80) begin
      enc_last     = 2'd0;
      enc_bytes[0] = enc_cp[7:0];
    end else if (enc_cp < 21'h800) begin
      enc_last     = 2'd1;
      enc_bytes[0] = {3'b110, enc_cp[10:6]};
      enc_bytes[1] = {2'b10, enc_cp[5:0]};
    end else if (enc_cp < 21'h10000) begin
      enc_last     = 2'd2;
      enc_bytes[0] = {4'b1110, enc_cp[15:12]};
      enc_bytes[1] = {2'b10, enc_cp[11:6]};
      enc_bytes[2] = {2'b10, enc_cp[5:0]};
    end else begin
      enc_last     = 2'd3;
      enc_bytes[0] = {5'b11110, enc_cp[20:18]};
      enc_bytes[1] = {2'b10, enc_cp[17:12]};
      enc_bytes[2] = {2'b10, enc_cp[11:6]};
      enc_bytes[3] = {2'b10, enc_cp[5:0]};
    end
  end

  always_comb begin
    active_next = act;
    esc_next    = esc_e;
    left_next   = left_e;
    acc_next    = acc_e;
    hsp_next    = hsp_e;
    hsb_next    = hsb_e;
    emit_enc    = 1'b0;
    job_valid   = 1'b0;
    fin         = 1'b0;
    fin_st      = ST_DATA;
    job         = '0;
    job.status  = ST_DATA;
    job.bytes[0] = c;

    if (raw.end_of_input) begin
      if (act) begin
        fin    = 1'b1;
        fin_st = ST_UNTERM;
      end
    end else if (act) begin
      if (c < CH_SPACE) begin
        fin    = 1'b1;
        fin_st = ST_CTRL;
      end else if (left_e != 3'd0) begin
        if (!hx[4]) begin
          fin    = 1'b1;
          fin_st = ST_BADHEX;
        end else begin
          left_next = left_dec;
          acc_next  = acc_hex;
          if (left_dec == 3'd0) begin
            if (!hsp_e) begin
              if (acc_hex <= CP_BMP_LOW || acc_hex >= CP_BMP_HIGH) begin
                emit_enc = 1'b1;
              end else if (acc_hex <= CP_HI_LAST) begin
                hsp_next = 1'b1;
                hsb_next = acc_hex[9:0];
                acc_next = 16'd0;
              end else begin
                fin    = 1'b1;
                fin_st = ST_LONELOW;
              end
            end else if (acc_hex >= CP_LO_FIRST && acc_hex <= CP_LO_LAST) begin
              emit_enc = 1'b1;
              hsp_next = 1'b0;
              hsb_next = 10'd0;
            end else begin
              fin    = 1'b1;
              fin_st = ST_BADSECOND;
            end
          end
        end
      end else if (esc_e) begin
        esc_next = 1'b0;
        if (hsp_e && c != CH_U) begin
          fin    = 1'b1;
          fin_st = ST_MISSING;
        end else begin
          job_valid = 1'b1;
          unique case (c)
            CH_QUOTE, CH_BSL, CH_SLASH: job.bytes[0] = c;
            CH_B: job.bytes[0] = 8'h08;
            CH_F: job.bytes[0] = 8'h0c;
            CH_N: job.bytes[0] = 8'h0a;
            CH_R: job.bytes[0] = 8'h0d;
            CH_T: job.bytes[0] = 8'h09;
            CH_U: begin
              job_valid = 1'b0;
              acc_next  = 16'd0;
              left_next = 3'd4;
            end
            default: begin
              job_valid = 1'b0;
              fin       = 1'b1;
              fin_st    = ST_BADESC;
            end
          endcase
        end
      end else if (c == CH_QUOTE) begin
        fin    = 1'b1;
        fin_st = ST_END;
      end else if (c == CH_BSL) begin
        esc_next = 1'b1;
      end else if (hsp_e) begin
        fin    = 1'b1;
        fin_st = ST_MISSING;
      end else begin
        job_valid = 1'b1;
      end
    end

    if (emit_enc) begin
      job_valid    = 1'b1;
      job.bytes    = enc_bytes;
      job.last_idx = enc_last;
    end

    // any end or error: single status word, decode state cleared
    if (fin) begin
      job_valid   = 1'b1;
      job.bytes   = '0;
      job.last_idx = 2'd0;
      job.status  = fin_st;
      active_next = 1'b0;
      esc_next    = 1'b0;
      left_next   = 3'd0;
      acc_next    = 16'd0;
      hsp_next    = 1'b0;
      hsb_next    = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      esc    <= 1'b0;
      left   <= 3'd0;
      acc    <= 16'd0;
      hsp    <= 1'b0;
      hsb    <= 10'd0;
    end else if (accept) begin
      active <= active_next;
      esc    <= esc_next;
      left   <= left_next;
      acc    <= acc_next;
      hsp    <= hsp_next;
      hsb    <= hsb_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/jsu_queue.sv -----
// ---------------------------------------------------------------------------
// jsu_queue : job queue
// Short FIFO of decoded jobs between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module jsu_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire jsu_pkg::job_t wr_job,
  input  wire logic          pop,
  output logic               full,
  output logic               nonempty,
  output jsu_pkg::job_t      head
);
  import jsu_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/jsu_back.sv -----
// ---------------------------------------------------------------------------
// jsu_back : result serializer
// Walks the head job one word per cycle while utf8 is ready and retires it after its last word.
// ---------------------------------------------------------------------------
`default_nettype none

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          nonempty,
  input  wire jsu_pkg::job_t head,
  output logic               pop,
  jsu_utf8_if.source         utf8
);
  import jsu_pkg::*;

  logic [1:0] idx;
  logic       at_last, fire;

  assign at_last          = (idx == head.last_idx);
  assign fire             = utf8.valid & utf8.ready;
  assign pop              = fire & at_last;
  assign utf8.valid       = nonempty;
  assign utf8.out_byte    = head.bytes[idx];
  assign utf8.status      = head.status;
  assign utf8.last_result = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= at_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ----- design/json_string_unescape_utf8_unit.sv -----
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_unit : JSON string body to UTF-8 decoder
// Resolves simple and \uXXXX escapes (with surrogate pairs), emits UTF-8
// bytes, reports the closing quote and decode errors.
// ---------------------------------------------------------------------------
//
//  channel | dir | fields                                   | word
//  --------+-----+------------------------------------------+-------------------
//  raw     | in  | data_byte[8] first_byte end_of_input      | one string byte
//  utf8    | out | out_byte[8] status[4] last_result         | one result
//
// Cycles: a raw byte is decoded in the cycle it is taken; one byte per cycle
//   sustained while each byte yields at most one result and utf8 is ready.
// A \u escape that completes a code point gives 1..4 words; the output side
//   drains one word per cycle while utf8 is ready, and input stalls only once
//   the job queue (QUEUE_DEPTH entries) is full.
// Reset (rst, synchronous) clears decode state and empties the queue.
// Stalls: raw.ready depends on queue fill only; utf8 backpressure holds the
//   head job and its word index.
// ---------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  jsu_raw_if.sink    raw,
  jsu_utf8_if.source utf8
);
  import jsu_pkg::*;

  // front -> queue
  logic q_push;
  job_t q_wr_job;
  // queue -> back
  logic q_full;
  logic q_nonempty;
  logic q_pop;
  job_t q_head;

  // classify and decode, one raw word per cycle while the queue is not full
  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .raw    (raw),
    .q_full (q_full),
    .push   (q_push),
    .job    (q_wr_job)
  );

  // decouples decode from output backpressure
  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_job   (q_wr_job),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  // serialize multi-byte jobs onto the output channel
  jsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (q_nonempty),
    .head     (q_head),
    .pop      (q_pop),
    .utf8     (utf8)
  );

endmodule

`default_nettype wire

// ----- design/jsu_checker.sv -----
// ---------------------------------------------------------------------------
// jsu_checker : port-level checks
// Watches the output channel of the unescape unit.
// ---------------------------------------------------------------------------
`default_nettype none

module jsu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [3:0] status,
  input wire logic       last_result
);
  import jsu_pkg::*;

  // end and error words always close a byte's results
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != 4'(ST_DATA) |-> last_result)
    else $error("status word not marked last");

  // status words carry a zero byte
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != 4'(ST_DATA) |-> out_byte == 8'd0)
    else $error("status word with nonzero byte");

  // no code outside the status set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= 4'(ST_UNTERM))
    else $error("status out of range");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
      && $stable(last_result))
    else $error("stalled output word changed");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (utf8.valid),
  .out_ready   (utf8.ready),
  .out_byte    (utf8.out_byte),
  .status      (utf8.status),
  .last_result (utf8.last_result)
);

`default_nettype wire

// ----- tb/sv/json_string_unescape_utf8_unit_tb.sv -----
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_unit_tb : self-checking bench for the JSON unescaper
// Feeds raw string bytes, predicts the UTF-8 and status words for each accepted
// byte, and checks every result word in order. Directed strings come first,
// then random strings that are mostly well formed and end in a closing quote,
// an error or a stream end. Both channels stall in random bursts.
// ---------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_unit_tb;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 200;   // words that reach a live string
  localparam int CALM_AFTER   = 160;   // no stalls past this many random words

  typedef struct packed {
    logic [7:0] data;
    status_t    st;
    logic       last;
  } utf8_word_t;

  // Decoder state mirror plus the queue of result words still to come.
  class utf8_scoreboard;
    bit         active;
    bit         esc;
    bit   [2:0] hex_left;
    bit  [15:0] acc;
    bit         hi_pend;
    bit   [9:0] hi_bits;
    utf8_word_t step_words[$];
    utf8_word_t expected_words[$];
    int         errors;
    int         words_in;
    int         live_words;
    int         words_out;
    bit         status_seen[9];

    function void clear_decode();
      active   = 1'b0;
      esc      = 1'b0;
      hex_left = '0;
      acc      = '0;
      hi_pend  = 1'b0;
      hi_bits  = '0;
    endfunction

    function void emit(bit [7:0] d, status_t st);
      utf8_word_t w;
      w.data = d;
      w.st   = st;
      w.last = 1'b0;
      step_words.push_back(w);
    endfunction

    // any error or end: one status word, string closes
    function void stop(status_t st);
      clear_decode();
      emit(8'h00, st);
    endfunction

    function void encode(bit [20:0] cp);
      if (cp < 21'h80) begin
        emit(cp[7:0], ST_DATA);
      end else if (cp < 21'h800) begin
        emit({3'b110, cp[10:6]}, ST_DATA);
        emit({2'b10, cp[5:0]}, ST_DATA);
      end else if (cp < 21'h10000) begin
        emit({4'b1110, cp[15:12]}, ST_DATA);
        emit({2'b10, cp[11:6]}, ST_DATA);
        emit({2'b10, cp[5:0]}, ST_DATA);
      end else begin
        emit({5'b11110, cp[20:18]}, ST_DATA);
        emit({2'b10, cp[17:12]}, ST_DATA);
        emit({2'b10, cp[11:6]}, ST_DATA);
        emit({2'b10, cp[5:0]}, ST_DATA);
      end
    endfunction

    function void take_hex(bit [7:0] c);
      int        nib;
      bit [15:0] cp;
      bit [20:0] full;
      if (c >= 8'h30 && c <= 8'h39) nib = int'(c) - 32'h30;
      else if (c >= 8'h61 && c <= 8'h66) nib = int'(c) - 32'h61 + 10;
      else if (c >= 8'h41 && c <= 8'h46) nib = int'(c) - 32'h41 + 10;
      else nib = -1;
      if (nib < 0) begin
        stop(ST_BADHEX);
        return;
      end
      hex_left = hex_left - 3'd1;
      acc = acc | (16'(nib) << (hex_left * 4));
      if (hex_left != 0) return;
      cp = acc;
      if (!hi_pend) begin
        if (cp <= CP_BMP_LOW || cp >= CP_BMP_HIGH) begin
          encode(21'(cp));
        end else if (cp <= CP_HI_LAST) begin
          hi_pend = 1'b1;
          hi_bits = cp[9:0];
          acc     = '0;
        end else begin
          stop(ST_LONELOW);
        end
      end else if (cp >= CP_LO_FIRST && cp <= CP_LO_LAST) begin
        full    = CP_PAIR_BASE + {1'b0, hi_bits, cp[9:0]};
        hi_pend = 1'b0;
        hi_bits = '0;
        encode(full);
      end else begin
        stop(ST_BADSECOND);
      end
    endfunction

    function void take_escape(bit [7:0] c);
      esc = 1'b0;
      if (hi_pend && c != CH_U) begin
        stop(ST_MISSING);
        return;
      end
      case (c)
        CH_QUOTE: emit(CH_QUOTE, ST_DATA);
        CH_BSL:   emit(CH_BSL, ST_DATA);
        CH_SLASH: emit(CH_SLASH, ST_DATA);
        CH_B:     emit(8'h08, ST_DATA);   // backspace
        CH_F:     emit(8'h0c, ST_DATA);   // form feed
        CH_N:     emit(8'h0a, ST_DATA);   // line feed
        CH_R:     emit(8'h0d, ST_DATA);   // carriage return
        CH_T:     emit(8'h09, ST_DATA);   // tab
        CH_U: begin
          acc      = '0;
          hex_left = 3'd4;
        end
        default:  stop(ST_BADESC);
      endcase
    endfunction

    function void take_byte(bit [7:0] c);
      if (c < CH_SPACE) stop(ST_CTRL);
      else if (hex_left != 0) take_hex(c);
      else if (esc) take_escape(c);
      else if (c == CH_QUOTE) stop(ST_END);
      else if (c == CH_BSL) esc = 1'b1;
      else if (hi_pend) stop(ST_MISSING);
      else emit(c, ST_DATA);
    endfunction

    // accepted raw word -> expected result words
    function void note_input(bit [7:0] d, bit first, bit eoi);
      step_words.delete();
      words_in++;
      if (first || active) live_words++;
      if (first) begin
        clear_decode();
        active = 1'b1;
      end
      if (eoi) begin
        if (active) stop(ST_UNTERM);
      end else if (active) begin
        take_byte(d);
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    function void check_result(logic [7:0] d, logic [3:0] st, logic last);
      utf8_word_t w;
      words_out++;
      if (st < 9) status_seen[st] = 1'b1;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: out_byte %02h status %0d last %0d", d, st, last);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (d !== w.data) begin
        $error("out_byte: expected %02h, got %02h", w.data, d);
        errors++;
      end
      if (st !== w.st) begin
        $error("status: expected %0d, got %0d", w.st, st);
        errors++;
      end
      if (last !== w.last) begin
        $error("last_result: expected %0d, got %0d", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  jsu_raw_if  raw_ch ();
  jsu_utf8_if utf8_ch ();

  json_string_unescape_utf8_unit dut (
    .clk  (clk),
    .rst  (rst),
    .raw  (raw_ch),
    .utf8 (utf8_ch)
  );

  utf8_scoreboard sb = new();

  bit         bursts_on = 1'b1;
  bit   [7:0] str_bytes[$];
  bit         str_eoi;
  int         strings_sent;
  int         cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: the run must wrap up well inside the limit.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: sample at the edge, then pick next ready (stall bursts).
  initial begin
    int stall_left;
    stall_left    = 0;
    utf8_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && utf8_ch.valid && utf8_ch.ready)
        sb.check_result(utf8_ch.out_byte, utf8_ch.status, utf8_ch.last_result);
      if (bursts_on && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 5);
      if (stall_left > 0) begin
        utf8_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        utf8_ch.ready <= 1'b1;
      end
    end
  end

  // One raw word, with an optional idle burst ahead of it. Returns at the
  // accepting edge, with valid still high.
  task automatic send_word(input bit [7:0] d, input bit first, input bit eoi);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      raw_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    raw_ch.valid        <= 1'b1;
    raw_ch.data_byte    <= d;
    raw_ch.first_byte   <= first;
    raw_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!raw_ch.ready) @(posedge clk);
    sb.note_input(d, first, eoi);
  endtask

  // Send the built string: first word flags the start, optional stream end.
  task automatic send_string();
    foreach (str_bytes[i]) send_word(str_bytes[i], i == 0, 1'b0);
    if (str_eoi) send_word(8'($urandom_range(0, 255)), str_bytes.size() == 0, 1'b1);
    str_bytes.delete();
    str_eoi = 1'b0;
    strings_sent++;
  endtask

  function automatic bit [7:0] hex_char(bit [3:0] n);
    if (n < 10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;   // mixed case
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) str_bytes.push_back(s[i]);
  endtask

  // \uXXXX with the given code unit
  task automatic push_u(input bit [15:0] v);
    str_bytes.push_back(CH_BSL);
    str_bytes.push_back(CH_U);
    for (int i = 3; i >= 0; i--) str_bytes.push_back(hex_char(v[i*4 +: 4]));
  endtask

  function automatic bit [7:0] plain_char();
    bit [7:0] c;
    do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSL);
    return c;
  endfunction

  // One well-formed piece of string content.
  task automatic add_piece();
    bit [15:0] edges[8] = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff,
                            16'h0800, 16'hd7ff, 16'he000, 16'hffff};
    bit [7:0]  simple[8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    case ($urandom_range(0, 9))
      0, 1, 2: str_bytes.push_back(plain_char());
      3, 4: begin
        str_bytes.push_back(CH_BSL);
        str_bytes.push_back(simple[$urandom_range(0, 7)]);
      end
      5: push_u(16'($urandom_range(0, 16'h7f)));
      6: push_u(16'($urandom_range(16'h80, 16'h7ff)));
      7: push_u($urandom_range(0, 1) ? 16'($urandom_range(16'h800, 16'hd7ff))
                                     : 16'($urandom_range(16'he000, 16'hffff)));
      8: push_u(edges[$urandom_range(0, 7)]);
      default: begin
        // surrogate pair -> 4-byte sequence
        push_u(16'($urandom_range(CP_HI_FIRST, CP_HI_LAST)));
        push_u(16'($urandom_range(CP_LO_FIRST, CP_LO_LAST)));
      end
    endcase
  endtask

  // Random string: content pieces, then a way to end (or not).
  task automatic build_string();
    int       r;
    bit [7:0] c;
    bit [15:0] v;
    repeat ($urandom_range(0, 6)) add_piece();
    r = $urandom_range(0, 99);
    if (r < 55) begin
      str_bytes.push_back(CH_QUOTE);
    end else if (r < 62) begin
      str_eoi = 1'b1;
    end else if (r < 67) begin
      str_bytes.push_back(8'($urandom_range(0, 31)));
    end else if (r < 72) begin
      // broken hex run: 0..3 good digits then a non-hex byte
      str_bytes.push_back(CH_BSL);
      str_bytes.push_back(CH_U);
      repeat ($urandom_range(0, 3)) str_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
      do c = 8'($urandom_range(32, 255));
      while (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
      str_bytes.push_back(c);
    end else if (r < 76) begin
      push_u(16'($urandom_range(CP_LO_FIRST, CP_LO_LAST)));
    end else if (r < 80) begin
      // high half followed by a \u that is not a low half
      push_u(16'($urandom_range(CP_HI_FIRST, CP_HI_LAST)));
      do v = 16'($urandom_range(0, 16'hffff)); while (v >= CP_LO_FIRST && v <= CP_LO_LAST);
      push_u(v);
    end else if (r < 85) begin
      // high half followed by anything but \u
      push_u(16'($urandom_range(CP_HI_FIRST, CP_HI_LAST)));
      if ($urandom_range(0, 1)) begin
        str_bytes.push_back(plain_char());
      end else begin
        str_bytes.push_back(CH_BSL);
        do c = 8'($urandom_range(32, 255)); while (c == CH_U);
        str_bytes.push_back(c);
      end
    end else if (r < 90) begin
      str_bytes.push_back(CH_BSL);
      do c = 8'($urandom_range(32, 255));
      while (c inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
      str_bytes.push_back(c);
    end else if (r < 94) begin
      // closing quote drops a pending high half
      push_u(16'($urandom_range(CP_HI_FIRST, CP_HI_LAST)));
      str_bytes.push_back(CH_QUOTE);
    end else begin
      repeat ($urandom_range(1, 8)) str_bytes.push_back(8'($urandom_range(0, 255)));
    end
    // trailing bytes, mostly after the string closed (ignored)
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) str_bytes.push_back(8'($urandom_range(0, 255)));
    if (!str_eoi && $urandom_range(0, 7) == 0) str_eoi = 1'b1;
  endtask

  initial begin
    int base;
    int seen;
    rst                 = 1'b1;
    raw_ch.valid        = 1'b0;
    raw_ch.data_byte    = '0;
    raw_ch.first_byte   = 1'b0;
    raw_ch.end_of_input = 1'b0;
    str_eoi             = 1'b0;
    strings_sent        = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    send_word(8'h5a, 1'b0, 1'b0);        // byte with no string open: ignored
    send_word(8'ha5, 1'b0, 1'b1);        // stream end with no string open
    send_word(8'hff, 1'b1, 1'b1);        // start and end at once: unterminated
    push_text("\\uD800\"");              // quote while high half waits
    send_string();
    push_text("\\udBfF\\uDFFF");         // highest code point, 4 bytes
    str_bytes.push_back(8'h1f);          // then a control character
    send_string();
    str_bytes.push_back(8'h00);          // control character as first byte
    send_string();
    str_bytes.push_back(8'hff);          // top byte passes through, then stream end
    str_eoi = 1'b1;
    send_string();

    // --- random strings ---
    base = sb.live_words;
    while (sb.live_words - base < RANDOM_WORDS) begin
      bursts_on = (sb.live_words - base) < CALM_AFTER;
      build_string();
      send_string();
    end
    raw_ch.valid <= 1'b0;
    bursts_on = 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);          // catch any stray words

    seen = 0;
    foreach (sb.status_seen[i]) seen += sb.status_seen[i];
    $display("Sent %0d strings in %0d raw words (%0d inside a live string).",
             strings_sent, sb.words_in, sb.live_words);
    $display("Checked %0d result words; %0d of 9 status codes observed.", sb.words_out, seen);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
